FILE: sv/psa_pkg.sv
package psa_pkg;

  // Default sizes of the allocator
  localparam int MAX_PAGES_DEF     = 1024;
  localparam int SLOTS_MAX_DEF     = 512;
  localparam int BITMAP_OFFSET_DEF = 8;
  localparam int PAGE_BYTES_DEF    = 8192;

  // Bitmap word geometry
  localparam int WORD_BITS  = 64;
  localparam int WORD_BYTES = 8;
  localparam int BIT_IW     = 6;

  // Port field widths
  localparam int PAGE_FW   = 10;
  localparam int SLOT_FW   = 9;
  localparam int OFF_FW    = 13;
  localparam int STATUS_FW = 2;
  localparam int SPP_W     = 10;
  localparam int RB_W      = 14;
  localparam int CFG_DW    = 14;
  localparam int CFG_IW    = 1;

  // Largest offset the result field can carry
  localparam int OFF_MAX = 8191;

  // Register reset values
  localparam logic [SPP_W-1:0] SPP_RESET = SPP_W'(512);
  localparam logic [RB_W-1:0]  RB_RESET  = RB_W'(16);

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_ERASE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_SLOTS  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_RECORD = 1'b1;

  // Result status codes
  localparam logic [STATUS_FW-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_FW-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_FW-1:0] ST_BAD_ERASE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_SET,
    S_ECHK,
    S_MUL,
    S_OUT
  } psa_state_t;

endpackage

FILE: sv/page_slot_allocator_core.sv
// Channel   Direction  Handshake              Payload
// request   in         in_valid / in_stall    req_type, page_in, slot_in
// result    out        out_valid / out_stall  page_out, slot_out, byte_offset, status
// config    in         cfg_we                 cfg_index, cfg_data
//
// One request is in work at a time. An insert on the head page scans the bitmap from its first
// word up to the word that holds the first free slot, reading one bitmap word per cycle from
// the single read port. Opening a fresh page clears its bitmap with one write per word.
// An erase reads the bitmap word of its slot, then clears the bit if the slot is in use.
// Reset is synchronous; the per-page stores need no clearing pass, since a page is written
// when it is opened. A stall on the result side holds the block in its last state.
module page_slot_allocator_core import psa_pkg::*; #(
  parameter int MAX_PAGES     = MAX_PAGES_DEF,
  parameter int SLOTS_MAX     = SLOTS_MAX_DEF,
  parameter int BITMAP_OFFSET = BITMAP_OFFSET_DEF,
  parameter int PAGE_BYTES    = PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [PAGE_FW-1:0]   page_in,
  input  logic [SLOT_FW-1:0]   slot_in,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PAGE_FW-1:0]   page_out,
  output logic [SLOT_FW-1:0]   slot_out,
  output logic [OFF_FW-1:0]    byte_offset,
  output logic [STATUS_FW-1:0] status,
  // configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  localparam int PW       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW       = $clog2(MAX_PAGES + 1);
  localparam int WPP      = (SLOTS_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int WIW      = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int WCW      = $clog2(WPP + 1);
  localparam int SW       = $clog2(SLOTS_MAX);
  localparam int NW       = $clog2(SLOTS_MAX + 1);
  localparam int BM_DEPTH = MAX_PAGES * WPP;
  localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  localparam int PRODW    = SW + RB_W;
  localparam int SUMW     = PRODW + 1;
  localparam int CAP      = (PAGE_BYTES - 1 < OFF_MAX) ? PAGE_BYTES - 1 : OFF_MAX;

  // Per-page record: occupancy count and link in the list of pages with room
  typedef struct packed {
    logic [NW-1:0] count;
    logic          on_list;
    logic          next_valid;
    logic [PW-1:0] next_page;
  } page_info_t;

  localparam int INFO_W = $bits(page_info_t);

  function automatic logic [BM_AW-1:0] bm_addr(input logic [PW-1:0] pg,
                                                input logic [WIW-1:0] wd);
    return BM_AW'(pg) * BM_AW'(WPP) + BM_AW'(wd);
  endfunction

  psa_state_t state, state_next;

  // Configuration and allocator state
  logic [SPP_W-1:0] slots_per_page;
  logic [RB_W-1:0]  record_bytes;
  logic [PW-1:0]    head_page;
  logic             head_valid;
  logic [CW-1:0]    pages_opened;

  // Work registers of the request in progress
  logic [PW-1:0]          wpage;
  logic [SW-1:0]          wslot;
  logic [PAGE_FW-1:0]     pout;
  logic [SLOT_FW-1:0]     sout;
  logic [STATUS_FW-1:0]   rstat;
  logic [WIW-1:0]         chk_word;
  logic [WIW-1:0]         clr_word;
  logic [BM_AW-1:0]       set_addr;
  logic [WORD_BITS-1:0]   set_word;
  logic [PRODW-1:0]       prod;

  // Memory ports
  logic                 bm_we, bm_re;
  logic [BM_AW-1:0]     bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
  logic                 info_we, info_re;
  logic [PW-1:0]        info_waddr, info_raddr;
  logic [INFO_W-1:0]    info_wdata, info_rdata;
  page_info_t           info_q, info_d;

  // Decode signals
  logic                 accept;
  logic                 open_full;
  logic                 erase_bad;
  logic [NW-1:0]        eff;
  logic [WCW-1:0]       words_used;
  logic [WORD_BITS-1:0] lim, free_bits;
  logic                 found;
  logic [BIT_IW-1:0]    fidx;
  logic [WCW-1:0]       nxt;
  logic                 more;
  logic                 clr_last;
  logic [NW-1:0]        count_inc, count_dec;
  logic                 page_full;
  logic                 occ;
  logic                 relink;
  logic                 out_load;
  logic [SUMW-1:0]      header, off_sum;

  assign info_q = info_rdata;

  psa_ram #(.WIDTH(WORD_BITS), .DEPTH(BM_DEPTH)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  psa_ram #(.WIDTH(INFO_W), .DEPTH(MAX_PAGES)) u_info (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .re    (info_re),
    .raddr (info_raddr),
    .rdata (info_rdata)
  );

  // Take one request at a time; hold off while any state but idle runs
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // Usable slots, clamped to 1..SLOTS_MAX, and the bitmap words they span
  always_comb begin
    if (slots_per_page == '0) begin
      eff = NW'(1);
    end else if (slots_per_page > SLOTS_MAX) begin
      eff = NW'(SLOTS_MAX);
    end else begin
      eff = NW'(slots_per_page);
    end
  end

  assign words_used = WCW'(({1'b0, eff} + (NW + 1)'(WORD_BITS - 1)) >> BIT_IW);
  assign header     = SUMW'(BITMAP_OFFSET) + SUMW'(words_used) * SUMW'(WORD_BYTES);
  assign off_sum    = header + SUMW'(prod);

  assign open_full = !head_valid && (pages_opened >= CW'(MAX_PAGES));
  assign erase_bad = (page_in >= pages_opened) || (slot_in >= SLOTS_MAX);

  // Scan: mask the word just read down to usable slots and find the lowest free one
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      lim[b] = ({chk_word, BIT_IW'(b)} < eff);
    end
    free_bits = ~bm_rdata & lim;
    fidx      = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        fidx = BIT_IW'(b);
      end
    end
  end

  assign found    = |free_bits;
  assign nxt      = WCW'(chk_word) + WCW'(1);
  assign more     = nxt < words_used;
  assign clr_last = (clr_word == WIW'(WPP - 1));

  assign count_inc = info_q.count + NW'(1);
  assign page_full = count_inc >= eff;
  assign count_dec = (info_q.count != '0) ? info_q.count - NW'(1) : '0;
  assign occ       = bm_rdata[wslot[BIT_IW-1:0]];
  assign relink    = !info_q.on_list && (count_dec < eff);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_INSERT: begin
              if (head_valid) begin
                state_next = S_SCAN;
              end else if (open_full) begin
                state_next = S_OUT;
              end else begin
                state_next = S_CLEAR;
              end
            end
            REQ_ERASE: begin
              state_next = erase_bad ? S_OUT : S_ECHK;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_MUL;
        end
      end
      S_SCAN: begin
        if (found) begin
          state_next = S_SET;
        end else if (!more) begin
          state_next = S_OUT;
        end
      end
      S_SET:   state_next = S_MUL;
      S_ECHK:  state_next = occ ? S_MUL : S_OUT;
      S_MUL:   state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port drive per state
  always_comb begin
    bm_we      = 1'b0;
    bm_waddr   = set_addr;
    bm_wdata   = set_word;
    bm_re      = 1'b0;
    bm_raddr   = bm_addr(head_page, '0);
    info_we    = 1'b0;
    info_waddr = wpage;
    info_d     = info_q;
    info_re    = 1'b0;
    info_raddr = head_page;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_INSERT: begin
              // Start the scan of the head page with its first word
              bm_re   = head_valid;
              info_re = head_valid;
            end
            REQ_ERASE: begin
              bm_re      = !erase_bad;
              bm_raddr   = bm_addr(PW'(page_in), WIW'(slot_in >> BIT_IW));
              info_re    = !erase_bad;
              info_raddr = PW'(page_in);
            end
            default: begin
              bm_re   = 1'b0;
              info_re = 1'b0;
            end
          endcase
        end
      end
      S_CLEAR: begin
        // Clear the fresh page, claiming slot zero on the way
        bm_we    = 1'b1;
        bm_waddr = bm_addr(wpage, clr_word);
        bm_wdata = (clr_word == '0) ? WORD_BITS'(1) : '0;
        if (clr_last) begin
          info_we           = 1'b1;
          info_d.count      = NW'(1);
          info_d.on_list    = (eff != NW'(1));
          info_d.next_valid = 1'b0;
          info_d.next_page  = '0;
        end
      end
      S_SCAN: begin
        if (!found && more) begin
          bm_re    = 1'b1;
          bm_raddr = bm_addr(wpage, WIW'(nxt));
        end
        if (!found && !more) begin
          // No room on the head page: drop it from the list
          info_we           = 1'b1;
          info_d.on_list    = 1'b0;
          info_d.next_valid = 1'b0;
        end
      end
      S_SET: begin
        bm_we        = 1'b1;
        info_we      = 1'b1;
        info_d.count = count_inc;
        if (page_full) begin
          info_d.on_list    = 1'b0;
          info_d.next_valid = 1'b0;
        end
      end
      S_ECHK: begin
        if (occ) begin
          bm_we        = 1'b1;
          bm_wdata     = bm_rdata & ~(WORD_BITS'(1) << wslot[BIT_IW-1:0]);
          info_we      = 1'b1;
          info_d.count = count_dec;
          if (relink) begin
            info_d.on_list    = 1'b1;
            info_d.next_valid = head_valid;
            info_d.next_page  = head_page;
          end
        end
      end
      default: begin
        bm_we = 1'b0;
      end
    endcase
  end

  assign info_wdata = info_d;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slots_per_page <= SPP_RESET;
      record_bytes   <= RB_RESET;
      head_page      <= '0;
      head_valid     <= 1'b0;
      pages_opened   <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOTS:  slots_per_page <= cfg_data[SPP_W-1:0];
          CFG_RECORD: record_bytes   <= cfg_data[RB_W-1:0];
          default:    record_bytes   <= record_bytes;
        endcase
      end

      // Hold the result until it is transferred; a new load refills it
      out_valid <= out_load || (out_valid && out_stall);

      case (state)
        S_IDLE: begin
          if (accept && (req_type == REQ_INSERT) && !head_valid && !open_full) begin
            head_page    <= PW'(pages_opened);
            pages_opened <= pages_opened + CW'(1);
          end
        end
        S_CLEAR: begin
          if (clr_last) begin
            head_valid <= (eff != NW'(1));
          end
        end
        S_SCAN: begin
          if (!found && !more) begin
            head_page  <= info_q.next_page;
            head_valid <= info_q.next_valid;
          end
        end
        S_SET: begin
          if (page_full) begin
            head_page  <= info_q.next_page;
            head_valid <= info_q.next_valid;
          end
        end
        S_ECHK: begin
          if (occ && relink) begin
            head_page  <= wpage;
            head_valid <= 1'b1;
          end
        end
        default: begin
          head_valid <= head_valid;
        end
      endcase
    end
  end

  // Payload of the request in progress
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          wslot    <= SW'(slot_in);
          set_addr <= bm_addr(PW'(page_in), WIW'(slot_in >> BIT_IW));
          chk_word <= '0;
          clr_word <= '0;
          case (req_type)
            REQ_INSERT: begin
              // Page and slot come later from the scan or the fresh page
              wpage <= head_valid ? head_page : PW'(pages_opened);
              pout  <= '0;
              sout  <= '0;
              rstat <= open_full ? ST_FULL : ST_OK;
            end
            REQ_ERASE: begin
              wpage <= PW'(page_in);
              pout  <= page_in;
              sout  <= slot_in;
              rstat <= erase_bad ? ST_BAD_ERASE : ST_OK;
            end
            default: rstat <= ST_OK;
          endcase
        end
      end
      S_CLEAR: begin
        clr_word <= clr_word + WIW'(1);
        if (clr_last) begin
          wslot <= '0;
          pout  <= PAGE_FW'(wpage);
          sout  <= '0;
        end
      end
      S_SCAN: begin
        if (found) begin
          wslot    <= SW'({chk_word, fidx});
          pout     <= PAGE_FW'(wpage);
          sout     <= SLOT_FW'({chk_word, fidx});
          set_addr <= bm_addr(wpage, chk_word);
          set_word <= bm_rdata | (WORD_BITS'(1) << fidx);
        end else if (more) begin
          chk_word <= WIW'(nxt);
        end else begin
          rstat <= ST_FULL;
          pout  <= '0;
          sout  <= '0;
        end
      end
      S_ECHK: begin
        if (!occ) begin
          rstat <= ST_BAD_ERASE;
        end
      end
      S_MUL: begin
        prod <= PRODW'(wslot) * PRODW'(record_bytes);
      end
      default: begin
        rstat <= rstat;
      end
    endcase

    if (out_load) begin
      page_out <= pout;
      slot_out <= sout;
      status   <= rstat;
      if (rstat != ST_OK) begin
        byte_offset <= '0;
      end else if (off_sum > SUMW'(CAP)) begin
        byte_offset <= OFF_FW'(CAP);
      end else begin
        byte_offset <= OFF_FW'(off_sum);
      end
    end
  end

endmodule

FILE: sv/psa_ram.sv
module psa_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; hold the last word while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sim/tb_page_slot_allocator_core.sv
`timescale 1ns / 100ps

module tb_page_slot_allocator_core import psa_pkg::*;;

  // Result of one request as it leaves the block
  typedef struct packed {
    logic [PAGE_FW-1:0]   page;
    logic [SLOT_FW-1:0]   slot;
    logic [OFF_FW-1:0]    off;
    logic [STATUS_FW-1:0] st;
  } alloc_res_t;

  // Directed rows: a request, or a register write between requests
  typedef enum logic [1:0] {ROW_INS, ROW_ERA, ROW_SPP, ROW_RB} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [PAGE_FW-1:0] pg;
    logic [SLOT_FW-1:0] sl;
    logic [CFG_DW-1:0]  val;
    logic               typed;
    alloc_res_t         want;
  } plan_row_t;

  localparam alloc_res_t NONE = '0;

  // Offsets: 72 is the header plus eight bitmap words at the full slot count,
  // 16 is the header plus one word once the slot count drops to 64 or less.
  localparam plan_row_t DIRECTED [28] = '{
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd0,    9'd0,   13'd72,   ST_OK}},
    '{ROW_INS, 10'd1023, 9'd511, 14'd0,      1'b1, '{10'd0,    9'd1,   13'd88,   ST_OK}},
    '{ROW_ERA, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd0,    9'd0,   13'd72,   ST_OK}},
    // second erase of the same slot: slot already free
    '{ROW_ERA, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd0,    9'd0,   13'd0,    ST_BAD_ERASE}},
    // page never opened
    '{ROW_ERA, 10'd1023, 9'd511, 14'd0,      1'b1, '{10'd1023, 9'd511, 13'd0,    ST_BAD_ERASE}},
    '{ROW_ERA, 10'd0,    9'd511, 14'd0,      1'b1, '{10'd0,    9'd511, 13'd0,    ST_BAD_ERASE}},
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd0,    9'd0,   13'd72,   ST_OK}},
    // slot count 0 clamps to 1: the head page now has no free slot
    '{ROW_SPP, 10'd0,    9'd0,   14'd0,      1'b0, NONE},
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd0,    9'd0,   13'd0,    ST_FULL}},
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd1,    9'd0,   13'd16,   ST_OK}},
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd2,    9'd0,   13'd16,   ST_OK}},
    '{ROW_ERA, 10'd3,    9'd5,   14'd0,      1'b1, '{10'd3,    9'd5,   13'd0,    ST_BAD_ERASE}},
    // occupied slot above the usable count is freed normally
    '{ROW_ERA, 10'd0,    9'd1,   14'd0,      1'b1, '{10'd0,    9'd1,   13'd32,   ST_OK}},
    // all data bits set: slot count masks to 1023 and clamps to 512
    '{ROW_SPP, 10'd0,    9'd0,   14'h3FFF,   1'b0, NONE},
    '{ROW_RB,  10'd0,    9'd0,   14'h3FFF,   1'b0, NONE},
    // full page relinks at the head
    '{ROW_ERA, 10'd1,    9'd0,   14'd0,      1'b1, '{10'd1,    9'd0,   13'd72,   ST_OK}},
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd1,    9'd0,   13'd72,   ST_OK}},
    // offset saturates at the page end
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd1,    9'd1,   13'd8191, ST_OK}},
    '{ROW_ERA, 10'd0,    9'd0,   14'd0,      1'b1, '{10'd0,    9'd0,   13'd72,   ST_OK}},
    '{ROW_INS, 10'd512,  9'd256, 14'd0,      1'b0, NONE},
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b0, NONE},
    '{ROW_RB,  10'd0,    9'd0,   14'd0,      1'b0, NONE},
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b0, NONE},
    '{ROW_SPP, 10'd0,    9'd0,   14'd64,     1'b0, NONE},
    '{ROW_RB,  10'd0,    9'd0,   14'd8192,   1'b0, NONE},
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b0, NONE},
    '{ROW_ERA, 10'd2,    9'd0,   14'd0,      1'b0, NONE},
    '{ROW_INS, 10'd0,    9'd0,   14'd0,      1'b0, NONE}
  };

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 req_type;
  logic [PAGE_FW-1:0]   page_in;
  logic [SLOT_FW-1:0]   slot_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [PAGE_FW-1:0]   page_out;
  logic [SLOT_FW-1:0]   slot_out;
  logic [OFF_FW-1:0]    byte_offset;
  logic [STATUS_FW-1:0] status;
  logic                 cfg_we;
  logic [CFG_IW-1:0]    cfg_index;
  logic [CFG_DW-1:0]    cfg_data;

  // Allocator image kept alongside the block
  bit [SLOTS_MAX_DEF-1:0] occ_map [MAX_PAGES_DEF];
  int unsigned            fill_cnt [MAX_PAGES_DEF];
  int unsigned            link_page [MAX_PAGES_DEF];
  bit                     link_ok [MAX_PAGES_DEF];
  bit                     listed [MAX_PAGES_DEF];
  int unsigned            head_page;
  bit                     head_ok;
  int unsigned            opened;
  logic [SPP_W-1:0]       spp_reg;
  logic [RB_W-1:0]        rb_reg;

  alloc_res_t               grants_due [$];   // results still owed by the block, oldest first
  logic [PAGE_FW+SLOT_FW-1:0] held_records [$]; // {page, slot} of every live record
  int                       grants_seen;
  int                       errs;
  bit                       steady;           // no idling on either side while set

  page_slot_allocator_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .page_in    (page_in),
    .slot_in    (slot_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .page_out   (page_out),
    .slot_out   (slot_out),
    .byte_offset(byte_offset),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run: far above the slowest correct run
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp the programmed slot count to 1..SLOTS_MAX
  function automatic int unsigned usable();
    if (spp_reg < 1) return 1;
    if (spp_reg > SLOTS_MAX_DEF) return SLOTS_MAX_DEF;
    return spp_reg;
  endfunction

  // Header, bitmap words in use, then the slot; clip at the last byte of the page
  function automatic logic [OFF_FW-1:0] record_offset(int unsigned sl);
    longint unsigned words, off, cap;
    words = (usable() + 63) / 64;
    off = BITMAP_OFFSET_DEF + words * WORD_BYTES + longint'(sl) * rb_reg;
    cap = PAGE_BYTES_DEF - 1;
    if (cap > OFF_MAX) cap = OFF_MAX;
    if (off > cap) off = cap;
    return off[OFF_FW-1:0];
  endfunction

  // Drop the head page from the list of pages with room
  function automatic void drop_head();
    int unsigned p;
    p = head_page;
    listed[p] = 1'b0;
    if (link_ok[p]) head_page = link_page[p];
    else head_ok = 1'b0;
    link_ok[p] = 1'b0;
  endfunction

  // Advance the image by one request and return the result it must produce
  function automatic alloc_res_t allocate(logic rt, logic [PAGE_FW-1:0] pg,
                                          logic [SLOT_FW-1:0] sl);
    alloc_res_t  r;
    int unsigned eff, p, s;
    r = '0;
    eff = usable();
    if (rt == REQ_INSERT) begin
      r.st = ST_FULL;
      if (!head_ok) begin
        // list empty: open the next fresh page, or report exhaustion
        if (opened >= MAX_PAGES_DEF) return r;
        p = opened;
        opened++;
        occ_map[p] = '0;
        fill_cnt[p] = 0;
        link_ok[p] = 1'b0;
        listed[p] = 1'b1;
        head_page = p;
        head_ok = 1'b1;
      end
      p = head_page;
      s = 0;
      while (s < eff && occ_map[p][s]) s++;
      if (s >= eff) begin
        // head page left without room after the slot count was lowered
        drop_head();
        return r;
      end
      occ_map[p][s] = 1'b1;
      fill_cnt[p]++;
      if (fill_cnt[p] >= eff) drop_head();
      r.page = PAGE_FW'(p);
      r.slot = SLOT_FW'(s);
      r.off = record_offset(s);
      r.st = ST_OK;
    end else begin
      p = pg;
      s = sl;
      r.page = pg;
      r.slot = sl;
      r.st = ST_BAD_ERASE;
      if (p >= opened || s >= SLOTS_MAX_DEF || !occ_map[p][s]) return r;
      occ_map[p][s] = 1'b0;
      if (fill_cnt[p] > 0) fill_cnt[p]--;
      // a page that was off the list and has room again goes to the head
      if (!listed[p] && fill_cnt[p] < eff) begin
        link_page[p] = head_page;
        link_ok[p] = head_ok;
        listed[p] = 1'b1;
        head_page = p;
        head_ok = 1'b1;
      end
      r.off = record_offset(s);
      r.st = ST_OK;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until the transfer. Called and left at a falling edge.
  task automatic issue(logic rt, logic [PAGE_FW-1:0] pg, logic [SLOT_FW-1:0] sl,
                       logic typed, alloc_res_t want);
    alloc_res_t predicted;
    int         k;
    while (!steady && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    page_in  <= pg;
    slot_in  <= sl;
    predicted = allocate(rt, pg, sl);
    grants_due.insert(grants_due.size(), typed ? want : predicted);
    // track live records so that most erases hit something real
    if (predicted.st == ST_OK) begin
      if (rt == REQ_INSERT) begin
        held_records.insert(held_records.size(), {predicted.page, predicted.slot});
      end else begin
        for (k = 0; k < held_records.size(); k++) begin
          if (held_records[k] == {pg, sl}) begin
            held_records.delete(k);
            break;
          end
        end
      end
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Write a register once every owed result has come back
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SLOTS) spp_reg = val[SPP_W-1:0];
    else rb_reg = val[RB_W-1:0];
  endtask

  // Random traffic: inserts at the given share, erases mostly of live records
  task automatic run_phase(int n, int ins_pct);
    logic [PAGE_FW-1:0] pg;
    logic [SLOT_FW-1:0] sl;
    int                 k;
    repeat (n) begin
      pg = PAGE_FW'($urandom_range(MAX_PAGES_DEF - 1));
      sl = SLOT_FW'($urandom_range(SLOTS_MAX_DEF - 1));
      if ($urandom_range(99) < ins_pct) begin
        issue(REQ_INSERT, pg, sl, 1'b0, NONE);
      end else begin
        if (held_records.size() > 0 && $urandom_range(99) < 70) begin
          k = $urandom_range(held_records.size() - 1);
          {pg, sl} = held_records[k];
        end
        issue(REQ_ERASE, pg, sl, 1'b0, NONE);
      end
    end
  endtask

  initial begin
    plan_row_t row;
    rst       = 1'b1;
    in_valid  = 1'b0;
    req_type  = REQ_INSERT;
    page_in   = '0;
    slot_in   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SLOTS;
    cfg_data  = '0;
    steady    = 1'b0;
    spp_reg   = SPP_RESET;
    rb_reg    = RB_RESET;
    head_page = 0;
    head_ok   = 1'b0;
    opened    = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: extremes, bad erases, clamping, relinks, saturation
    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_INS: issue(REQ_INSERT, row.pg, row.sl, row.typed, row.want);
        ROW_ERA: issue(REQ_ERASE, row.pg, row.sl, row.typed, row.want);
        ROW_SPP: write_reg(CFG_SLOTS, row.val);
        ROW_RB:  write_reg(CFG_RECORD, row.val);
        default: ;
      endcase
    end

    // Full pages: insert-heavy so the scan walks deep into the bitmap and pages fill
    write_reg(CFG_SLOTS, CFG_DW'(SLOTS_MAX_DEF));
    write_reg(CFG_RECORD, CFG_DW'($urandom_range(40, 1)));
    run_phase(150, 96);
    steady = 1'b1;
    run_phase(150, 96);
    steady = 1'b0;
    run_phase(250, 96);

    // One slot per page: open pages until none is left, then mix in erases
    write_reg(CFG_SLOTS, CFG_DW'(1));
    write_reg(CFG_RECORD, CFG_DW'($urandom_range(16383)));
    while (opened < MAX_PAGES_DEF) begin
      issue(REQ_INSERT, PAGE_FW'($urandom_range(MAX_PAGES_DEF - 1)),
            SLOT_FW'($urandom_range(SLOTS_MAX_DEF - 1)), 1'b0, NONE);
    end
    run_phase(80, 70);

    // Mid-size pages over an exhausted pool: relinks and erases above the usable count
    write_reg(CFG_SLOTS, CFG_DW'(70));
    write_reg(CFG_RECORD, CFG_DW'($urandom_range(16383)));
    run_phase(100, 55);

    // Drain, then leave room for anything stray
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errs == 0 && grants_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random stalls, plus one long hold-off so the block backs up into its input
  initial begin
    bit held_off;
    held_off  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && grants_seen >= 60) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end
      out_stall <= !steady && ($urandom_range(99) < 10);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      errs++;
    end
  endtask

  // Compare each result transfer with the oldest owed result
  always @(posedge clk) begin
    alloc_res_t want;
    if (!rst && out_valid && !out_stall) begin
      grants_seen++;
      if (grants_due.size() == 0) begin
        $error("result with nothing owed: page %0d slot %0d status %0d",
               page_out, slot_out, status);
        errs++;
      end else begin
        want = grants_due.pop_front();
        check_field("page_out", want.page, page_out);
        check_field("slot_out", want.slot, slot_out);
        check_field("byte_offset", want.off, byte_offset);
        check_field("status", want.st, status);
      end
    end
  end

endmodule
